FILE: rtl/ycsr_pkg.sv
package ycsr_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int POS_W   = 11;
	localparam int SPAN_W  = 12;
	localparam int PROD_W  = POS_W + SPAN_W;
	localparam int SX_W    = PROD_W + 2;
	localparam int CNT_W   = $clog2(PROD_W + 1);
	localparam int ENTRY_W = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ROW   = 2'd1;
	localparam logic [1:0] OP_PIXEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE   = 3'd7;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] position;
		logic [7:0]       luma_even;
		logic [7:0]       chroma_blue;
		logic [7:0]       luma_odd;
		logic [7:0]       chroma_red;
	} in_item_t;

	typedef struct packed {
		logic [10:0] source_row;
		logic [15:0] pixel_color;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [SPAN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_stat_t;

	typedef struct packed {
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [ENTRY_W-1:0] wr_data;
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
	} store_req_t;

endpackage

FILE: rtl/ycsr_divider.sv
module ycsr_divider
	import ycsr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  count_q;
	logic [SPAN_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [SPAN_W-1:0] divisor_q;

	logic [SPAN_W:0]   shifted;
	logic [SPAN_W+1:0] diff;

	always_comb begin
		shifted = {rem_q, quo_q[PROD_W-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (count_q == CNT_W'(1));
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[SPAN_W+1]) begin
				rem_q <= diff[SPAN_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SPAN_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule

FILE: rtl/ycsr_line_store.sv
module ycsr_line_store
	import ycsr_pkg::*;
(
	input  logic               clk,
	input  store_req_t         req,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

FILE: rtl/ycsr_color.sv
module ycsr_color
	import ycsr_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [ENTRY_W-1:0] entry,
	input  logic               odd,
	output logic [15:0]        color
);

	logic        [7:0]  y;
	logic        [7:0]  c;
	logic signed [18:0] c19;
	logic signed [18:0] d19;
	logic signed [18:0] e19;

	logic signed [18:0] tc_s1;
	logic signed [18:0] tre_s1;
	logic signed [18:0] tge_s1;
	logic signed [18:0] tgd_s1;
	logic signed [18:0] tbd_s1;

	logic signed [18:0] r_sum;
	logic signed [18:0] g_sum;
	logic signed [18:0] b_sum;
	logic        [7:0]  r8;
	logic        [7:0]  g8;
	logic        [7:0]  b8;

	function automatic logic [7:0] sat8(input logic signed [18:0] x);
		logic signed [18:0] s;
		s = x >>> 8;
		if (s < 0) begin
			return 8'd0;
		end else if (s > 19'sd255) begin
			return 8'd255;
		end else begin
			return s[7:0];
		end
	endfunction

	always_comb begin
		y   = odd ? entry[23:16] : entry[7:0];
		c   = (y < 8'd16) ? 8'd0 : y - 8'd16;
		c19 = signed'(19'(c));
		d19 = signed'(19'(entry[15:8])) - 19'sd128;
		e19 = signed'(19'(entry[31:24])) - 19'sd128;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1  <= c19 * 19'sd298;
			tre_s1 <= e19 * 19'sd409;
			tge_s1 <= e19 * 19'sd208;
			tgd_s1 <= d19 * 19'sd100;
			tbd_s1 <= d19 * 19'sd516;
		end
	end

	always_comb begin
		r_sum = tc_s1 + tre_s1 + 19'sd128;
		g_sum = tc_s1 - tgd_s1 - tge_s1 + 19'sd128;
		b_sum = tc_s1 + tbd_s1 + 19'sd128;
		r8    = sat8(r_sum);
		g8    = sat8(g_sum);
		b8    = sat8(b_sum);
		color = {r8[7:3], g8[7:2], b8[7:3]};
	end

endmodule

FILE: rtl/yuyv_crop_scale_rgb565.sv
// YUYV line-store preview scaler with BT.601 conversion to RGB565. One item is taken at a
// time and every item gives one result. A macropixel write or an unknown op goes straight
// to the output state; a row mapping and a pixel render both wait on the shared restoring
// divider, which produces one quotient bit a cycle over the 23-bit product of position and
// window span. The next item is accepted while a result still waits at the output
// register. The line store has no clearing pass: an entry must be written before it is
// rendered. Configuration writes are always taken and must only be made while the block
// is idle.
module yuyv_crop_scale_rgb565
	import ycsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MAP,
		ST_CLAMP,
		ST_READ,
		ST_CONV,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [SPAN_W-1:0] source_width_q;
	logic [10:0]       window_left_q;
	logic [10:0]       window_top_q;
	logic [SPAN_W-1:0] window_width_q;
	logic [SPAN_W-1:0] window_height_q;
	logic [SPAN_W-1:0] target_width_q;
	logic [SPAN_W-1:0] target_height_q;
	logic [1:0]        mirror_q;

	logic [1:0]             op_q;
	logic [POS_W-1:0]       pos_q;
	logic [PROD_W-1:0]      prod_q;
	logic [PROD_W-1:0]      offs_q;
	logic signed [SX_W-1:0] sx_q;
	logic                   odd_q;
	logic                   in_range_q;
	logic [10:0]            row_q;
	logic [15:0]            pix_q;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic [SPAN_W-1:0]      span;
	logic [SPAN_W-1:0]      target;
	logic signed [SX_W-1:0] sx_next;
	logic signed [SX_W-1:0] sx0;
	logic signed [SX_W-1:0] sw_s;
	logic signed [SX_W-1:0] sel;
	logic [SX_W-2:0]        idx_full;
	logic                   in_range;

	logic               accept;
	div_req_t           div_req;
	div_stat_t          div_stat;
	store_req_t         store_req;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] entry;
	logic [15:0]        color;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		span    = (op_q == OP_ROW) ? window_height_q : window_width_q;
		target  = (op_q == OP_ROW) ? target_height_q : target_width_q;
		sx_next = mirror_q[0]
			? SX_W'(window_left_q) + SX_W'(window_width_q) - SX_W'(1) - SX_W'(offs_q)
			: SX_W'(window_left_q) + SX_W'(offs_q);
		sx0  = {sx_q[SX_W-1:1], 1'b0};
		sw_s = SX_W'(source_width_q);
		sel  = (sx0 >= sw_s - SX_W'(1)) ? sw_s - SX_W'(2) : sx0;
		if (sel < 0) begin
			sel = '0;
		end
		idx_full = sel[SX_W-1:1];
		in_range = idx_full < (SX_W-1)'(STORE_DEPTH);
	end

	always_comb begin
		div_req.start    = (state_q == ST_DIV_GO);
		div_req.dividend = prod_q;
		div_req.divisor  = target;

		store_req.wr_en   = accept && (in_data.op == OP_WRITE)
			&& (32'(in_data.position) < STORE_DEPTH);
		store_req.wr_addr = ADDR_W'(in_data.position);
		store_req.wr_data = {in_data.chroma_red, in_data.luma_odd,
			in_data.chroma_blue, in_data.luma_even};
		store_req.rd_en   = (state_q == ST_CLAMP);
		store_req.rd_addr = ADDR_W'(idx_full);

		entry = in_range_q ? rd_data : '0;
	end

	ycsr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	ycsr_line_store u_line_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	ycsr_color u_color (
		.clk   (clk),
		.en    (state_q == ST_READ),
		.entry (entry),
		.odd   (odd_q),
		.color (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			source_width_q  <= 12'd640;
			window_left_q   <= 11'd0;
			window_top_q    <= 11'd0;
			window_width_q  <= 12'd640;
			window_height_q <= 12'd480;
			target_width_q  <= 12'd1024;
			target_height_q <= 12'd600;
			mirror_q        <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
					REG_WINDOW_LEFT:   window_left_q   <= cfg_data[10:0];
					REG_WINDOW_TOP:    window_top_q    <= cfg_data[10:0];
					REG_WINDOW_WIDTH:  window_width_q  <= cfg_data;
					REG_WINDOW_HEIGHT: window_height_q <= cfg_data;
					REG_TARGET_WIDTH:  target_width_q  <= cfg_data;
					REG_TARGET_HEIGHT: target_height_q <= cfg_data;
					REG_MIRROR_MODE:   mirror_q        <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= in_data.op;
						pos_q <= in_data.position;
						row_q <= '0;
						pix_q <= '0;
						if (in_data.op == OP_ROW || in_data.op == OP_PIXEL) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= pos_q * span;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						offs_q  <= (target == '0) ? '0 : div_stat.quotient;
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					if (op_q == OP_ROW) begin
						row_q <= mirror_q[1]
							? window_top_q + window_height_q[10:0] - 11'd1 - offs_q[10:0]
							: window_top_q + offs_q[10:0];
						state_q <= ST_FIN;
					end else begin
						sx_q    <= sx_next;
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					odd_q      <= sx_q[0];
					in_range_q <= in_range;
					state_q    <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					pix_q   <= color;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_item_q.source_row  <= row_q;
						out_item_q.pixel_color <= pix_q;
						out_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while previous one still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while block idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		store_req.rd_en |-> !store_req.wr_en)
		else $error("line store read and write in same cycle");
`endif

endmodule

FILE: sim/yuyv_crop_scale_rgb565_tb.sv
`timescale 1ns / 100ps

module yuyv_crop_scale_rgb565_tb;
	import ycsr_pkg::*;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 112;
	localparam int HOLD_CYCLES     = 200;
	localparam int IDLE_LIMIT      = 1000;
	localparam int DRAIN_CYCLES    = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	in_item_t           pending_items[$];
	out_item_t          expected_q[$];
	out_item_t          want;
	logic [CFG_DATA_W-1:0] reg_val [8];
	logic [ENTRY_W-1:0] line_copy [STORE_DEPTH];
	bit                 planned_written [STORE_DEPTH];

	int in_gap_max = 5;
	int out_gap_max = 5;
	int phase_no = 0;
	int in_gap = 0;
	int out_wait = 0;
	int stall_draw = 0;
	int hold_count = 0;
	int idle_cycles = 0;
	int errors = 0;
	int results_seen = 0;
	int items_queued = 0;
	int rows_mapped = 0;
	int pixels_rendered = 0;
	int settings_applied = 0;

	yuyv_crop_scale_rgb565 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint scaled_offset(input longint pos, input longint span,
		input longint target);
		if (target == 0)
			return 0;
		return (pos * span) / target;
	endfunction

	// macropixel index that an output column lands on, plus which luma it takes
	function automatic int column_entry(input logic [POS_W-1:0] col, output bit odd);
		longint cx, sx, sx0;
		cx = scaled_offset(col, reg_val[REG_WINDOW_WIDTH], reg_val[REG_TARGET_WIDTH]);
		if (reg_val[REG_MIRROR_MODE][0])
			sx = longint'(reg_val[REG_WINDOW_LEFT]) + longint'(reg_val[REG_WINDOW_WIDTH])
				- 1 - cx;
		else
			sx = longint'(reg_val[REG_WINDOW_LEFT]) + cx;
		odd = sx[0];
		if (odd)
			sx0 = sx - 1;
		else
			sx0 = sx;
		if (sx0 >= longint'(reg_val[REG_SOURCE_WIDTH]) - 1)
			sx0 = longint'(reg_val[REG_SOURCE_WIDTH]) - 2;
		if (sx0 < 0)
			sx0 = 0;
		return int'(sx0 >>> 1);
	endfunction

	function automatic logic [7:0] clip8(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [15:0] bt601_rgb565(input logic [7:0] y, input logic [7:0] cb,
		input logic [7:0] cr);
		int c, d, e;
		logic [7:0] r, g, b;
		c = int'(y) - 16;
		if (c < 0)
			c = 0;
		d = int'(cb) - 128;
		e = int'(cr) - 128;
		r = clip8((298 * c + 409 * e + 128) >>> 8);
		g = clip8((298 * c - 100 * d - 208 * e + 128) >>> 8);
		b = clip8((298 * c + 516 * d + 128) >>> 8);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic out_item_t scaler_result(input in_item_t it);
		out_item_t res;
		longint cy, sy;
		bit odd;
		int idx;
		logic [ENTRY_W-1:0] entry;
		res = '0;
		case (it.op)
			OP_WRITE: begin
				if (it.position < STORE_DEPTH)
					line_copy[it.position] = {it.chroma_red, it.luma_odd, it.chroma_blue,
						it.luma_even};
			end
			OP_ROW: begin
				rows_mapped++;
				cy = scaled_offset(it.position, reg_val[REG_WINDOW_HEIGHT],
					reg_val[REG_TARGET_HEIGHT]);
				if (reg_val[REG_MIRROR_MODE][1])
					sy = longint'(reg_val[REG_WINDOW_TOP])
						+ longint'(reg_val[REG_WINDOW_HEIGHT]) - 1 - cy;
				else
					sy = longint'(reg_val[REG_WINDOW_TOP]) + cy;
				res.source_row = sy[POS_W-1:0];
			end
			OP_PIXEL: begin
				pixels_rendered++;
				idx = column_entry(it.position, odd);
				entry = (idx < STORE_DEPTH) ? line_copy[idx] : '0;
				res.pixel_color = bt601_rgb565(odd ? entry[23:16] : entry[7:0], entry[15:8],
					entry[31:24]);
			end
			default: ;
		endcase
		return res;
	endfunction

	// a pixel whose macropixel has never been loaded gets a load queued ahead of it
	task automatic queue_item(input logic [1:0] op, input int pos, input logic [31:0] data);
		in_item_t it;
		bit odd;
		int idx;
		it.op = op;
		it.position = pos[POS_W-1:0];
		{it.chroma_red, it.luma_odd, it.chroma_blue, it.luma_even} = data;
		if (op == OP_PIXEL) begin
			idx = column_entry(it.position, odd);
			if (idx < STORE_DEPTH && !planned_written[idx])
				queue_item(OP_WRITE, idx, $urandom);
		end
		if (op == OP_WRITE && pos < STORE_DEPTH)
			planned_written[pos] = 1'b1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic int pick_coord(input logic [CFG_DATA_W-1:0] size);
		if (size == 0 || $urandom_range(0, 7) == 0)
			return $urandom_range(0, 2047);
		return $urandom_range(0, (size > 2048 ? 2048 : size) - 1);
	endfunction

	task automatic queue_phase_traffic();
		int start, col, base, n;
		bit odd;
		start = items_queued;
		while (items_queued - start < ITEMS_PER_PHASE) begin
			if ($urandom_range(0, 9) < 7) begin
				// map a row, load a run of macropixels, then render across them
				queue_item(OP_ROW, pick_coord(reg_val[REG_TARGET_HEIGHT]), $urandom);
				col = pick_coord(reg_val[REG_TARGET_WIDTH]);
				base = column_entry(col[POS_W-1:0], odd);
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					if (base + k < STORE_DEPTH)
						queue_item(OP_WRITE, base + k, $urandom);
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					queue_item(OP_PIXEL, col + k * $urandom_range(0, 3), $urandom);
			end else
				queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_LEFT, REG_WINDOW_TOP: reg_val[idx] = {1'b0, val[10:0]};
			REG_MIRROR_MODE: reg_val[idx] = {10'd0, val[1:0]};
			default: reg_val[idx] = val;
		endcase
	endtask

	task automatic apply_setting(input int p);
		logic [CFG_DATA_W-1:0] plan [8];
		case (p)
			1: plan = '{12'd2, 12'd0, 12'd0, 12'd2, 12'd2, 12'd1, 12'd1, 12'd0};
			2: plan = '{12'd2048, 12'd2047, 12'd2047, 12'd2048, 12'd2048, 12'd2048, 12'd2048,
				12'd3};
			3: plan = '{12'd0, 12'd5, 12'd7, 12'd640, 12'd480, 12'd0, 12'd0, 12'd1};
			4: plan = '{12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff};
			5: plan = '{12'd1, 12'd0, 12'd0, 12'd6, 12'd3, 12'd640, 12'd480, 12'd2};
			default: begin
				if (p % 2 == 1) begin
					foreach (plan[r])
						plan[r] = CFG_DATA_W'($urandom);
				end else begin
					plan[REG_SOURCE_WIDTH] = CFG_DATA_W'($urandom_range(2, 2048));
					plan[REG_WINDOW_LEFT] = CFG_DATA_W'($urandom_range(0, 2047));
					plan[REG_WINDOW_TOP] = CFG_DATA_W'($urandom_range(0, 2047));
					plan[REG_WINDOW_WIDTH] = CFG_DATA_W'(2 * $urandom_range(1, 1024));
					plan[REG_WINDOW_HEIGHT] = CFG_DATA_W'($urandom_range(2, 2048));
					plan[REG_TARGET_WIDTH] = CFG_DATA_W'($urandom_range(1, 2048));
					plan[REG_TARGET_HEIGHT] = CFG_DATA_W'($urandom_range(1, 2048));
					plan[REG_MIRROR_MODE] = CFG_DATA_W'($urandom_range(0, 3));
				end
			end
		endcase
		for (int r = 0; r < 8; r++)
			write_reg(r[CFG_IDX_W-1:0], plan[r]);
		settings_applied++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(scaler_result(in_data));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					in_gap <= $urandom_range(0, in_gap_max);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
		end else if (out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: source_row %0d pixel_color %h",
					out_item.source_row, out_item.pixel_color);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (out_item.source_row !== want.source_row) begin
					$error("source_row expected %0d got %0d", want.source_row,
						out_item.source_row);
					errors++;
				end
				if (out_item.pixel_color !== want.pixel_color) begin
					$error("pixel_color expected %h got %h", want.pixel_color,
						out_item.pixel_color);
					errors++;
				end
			end
			// one long back-pressure stretch per phase while items are still queued
			if (hold_count < phase_no && pending_items.size() >= 20) begin
				hold_count++;
				stall_draw = HOLD_CYCLES;
			end else
				stall_draw = $urandom_range(0, out_gap_max);
			out_wait <= stall_draw;
			out_ready <= (stall_draw == 0);
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			out_ready <= (out_wait == 1);
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no handshake for %0d cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		reg_val = '{12'd640, 12'd0, 12'd0, 12'd640, 12'd480, 12'd1024, 12'd600, 12'd0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values, luma and chroma extremes, writes past the store, unknown op
		queue_item(OP_WRITE, 0, 32'hffff_0000);
		queue_item(OP_WRITE, 1, 32'h80eb_800f);
		queue_item(OP_WRITE, 2, 32'h8010_8010);
		queue_item(OP_WRITE, 319, 32'h0000_ffff);
		queue_item(OP_WRITE, STORE_DEPTH - 1, 32'hffff_ffff);
		queue_item(OP_WRITE, STORE_DEPTH, $urandom);
		queue_item(OP_WRITE, 2047, $urandom);
		queue_item(OP_ROW, 0, $urandom);
		queue_item(OP_ROW, 599, $urandom);
		queue_item(OP_ROW, 2047, $urandom);
		queue_item(OP_PIXEL, 0, $urandom);
		queue_item(OP_PIXEL, 1, $urandom);
		queue_item(OP_PIXEL, 4, $urandom);
		queue_item(OP_PIXEL, 5, $urandom);
		queue_item(OP_PIXEL, 7, $urandom);
		queue_item(OP_PIXEL, 1023, $urandom);
		queue_item(OP_PIXEL, 2047, $urandom);
		queue_item(OP_UNKNOWN, 0, $urandom);
		queue_item(OP_UNKNOWN, 2047, 32'hffff_ffff);
		wait_drained();

		for (int p = 1; p < PHASES; p++) begin
			apply_setting(p);
			phase_no = p;
			in_gap_max = (p % 4 == 3) ? 0 : 5;
			out_gap_max = in_gap_max;
			@(negedge clk);
			queue_phase_traffic();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			errors++;
		end
		$display("checked %0d results under the reset values and %0d register settings",
			results_seen, settings_applied);
		$display("%0d rows mapped, %0d pixels rendered, %0d mismatches", rows_mapped,
			pixels_rendered, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
